@@ design/wtc_pkg.sv @@
// shared types and constants for the winding turn counter controller
package wtc_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TURNS_PER_LINE = 2'd0,
    CFG_LINES_PER_ROLL = 2'd1,
    CFG_RESTART_DELAY  = 2'd2,
    CFG_COUNT_ON_FALL  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    PH_COUNT = 1'b0,
    PH_WAIT  = 1'b1
  } phase_t;

  // filter status after this tick's update, before any external clear
  typedef struct packed {
    logic level;
    logic rise;
    logic fall;
  } filt_stat_t;

  typedef struct packed {
    logic             run_out;
    logic             cut_out;
    logic [CNT_W-1:0] turns_out;
    logic [CNT_W-1:0] lines_out;
    logic [CNT_W-1:0] rolls_out;
    logic             extra_turn_out;
  } result_t;

endpackage

@@ design/wtc_if.sv @@
// valid/ready channel interfaces for tick items and result items
interface wtc_in_if;
  logic valid;
  logic ready;
  logic action;
  logic count_pin;
  logic reset_pin;
  logic plus_one_pin;

  modport source (output valid, action, count_pin, reset_pin, plus_one_pin, input ready);
  modport sink   (input valid, action, count_pin, reset_pin, plus_one_pin, output ready);
endinterface

interface wtc_out_if;
  logic        valid;
  logic        ready;
  logic        run_out;
  logic        cut_out;
  logic [15:0] turns_out;
  logic [15:0] lines_out;
  logic [15:0] rolls_out;
  logic        extra_turn_out;

  modport source (output valid, run_out, cut_out, turns_out, lines_out, rolls_out,
                  extra_turn_out, input ready);
  modport sink   (input valid, run_out, cut_out, turns_out, lines_out, rolls_out,
                  extra_turn_out, output ready);
endinterface

@@ design/wtc_filter.sv @@
// up/down integrating pin filter with hysteresis
module wtc_filter
  import wtc_pkg::*;
#(
  parameter int unsigned ON_LEVEL  = 20,
  parameter int unsigned OFF_LEVEL = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pin,
  input  logic       clear,
  output filt_stat_t stat
);

  localparam int unsigned W = $clog2(ON_LEVEL + 1);
  localparam logic [W-1:0] ON_V  = W'(ON_LEVEL);
  localparam logic [W-1:0] OFF_V = W'(OFF_LEVEL);

  logic [W-1:0] integ;
  logic [W-1:0] integ_next;
  logic         level;
  logic         hit_on;
  logic         hit_off;

  always_comb begin
    integ_next = integ;
    hit_on     = 1'b0;
    hit_off    = 1'b0;
    if (pin) begin
      if (integ < ON_V) begin
        integ_next = integ + 1'b1;
        hit_on     = (integ_next == ON_V);
      end
    end else if (integ != '0) begin
      integ_next = integ - 1'b1;
      hit_off    = (integ_next == OFF_V);
    end
  end

  always_comb begin
    stat.rise  = hit_on && !level;
    stat.fall  = hit_off && level;
    stat.level = hit_on ? 1'b1 : (hit_off ? 1'b0 : level);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      level <= 1'b0;
    end else if (step) begin
      integ <= integ_next;
      level <= stat.level && !clear;
    end
  end

endmodule

@@ design/wtc_core.sv @@
// line/roll sequencing, turn counting, restart delay and configuration registers
module wtc_core
  import wtc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 action,
  input  logic                 plus_one,
  input  filt_stat_t           cnt_stat,
  input  filt_stat_t           rst_stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output logic                 reset_clear,
  output result_t              res
);

  logic [CNT_W-1:0] turns_per_line;
  logic [CNT_W-1:0] lines_per_roll;
  logic [CNT_W-1:0] restart_delay;
  logic             count_on_fall;

  phase_t           phase, phase_next;
  logic             cut_flag, cut_flag_next;
  logic             run_flag, run_flag_next;
  logic             restart_pending, restart_pending_next;
  logic             delay_running, delay_running_next;
  logic [CNT_W-1:0] turn_count, turn_count_next;
  logic [CNT_W-1:0] line_count, line_count_next;
  logic [CNT_W-1:0] roll_count, roll_count_next;
  logic [CNT_W-1:0] delay_left, delay_left_next;

  logic             pulse;
  logic             expired;
  logic             rlevel;
  logic [CNT_W-1:0] turn_inc;
  logic [CNT_W-1:0] line_inc;
  logic [CNT_W:0]   cut_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      turns_per_line <= '0;
      lines_per_roll <= '0;
      restart_delay  <= '0;
      count_on_fall  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TURNS_PER_LINE: turns_per_line <= cfg_data;
        CFG_LINES_PER_ROLL: lines_per_roll <= cfg_data;
        CFG_RESTART_DELAY:  restart_delay  <= cfg_data;
        CFG_COUNT_ON_FALL:  count_on_fall  <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  assign pulse      = count_on_fall ? cnt_stat.fall : cnt_stat.rise;
  assign expired    = delay_running && (delay_left == '0);
  // expiry drops the filtered reset level unless a count pulse wins
  assign reset_clear = expired && !pulse;
  assign rlevel     = rst_stat.level && !reset_clear;
  assign cut_target = {1'b0, turns_per_line} + (CNT_W+1)'(plus_one);
  assign line_inc   = line_count + 1'b1;

  always_comb begin
    phase_next           = phase;
    cut_flag_next        = cut_flag;
    run_flag_next        = run_flag;
    restart_pending_next = restart_pending;
    delay_running_next   = delay_running;
    turn_count_next      = turn_count;
    line_count_next      = line_count;
    roll_count_next      = roll_count;
    delay_left_next      = delay_left;
    turn_inc             = turn_count;

    if (action == ACT_CMD) begin
      if (line_count >= lines_per_roll) restart_pending_next = 1'b1;
      line_count_next = '0;
      turn_count_next = '0;
    end else begin
      if (rst_stat.level) begin
        turn_count_next = '0;
        cut_flag_next   = 1'b0;
      end
      if (delay_running && delay_left != '0) delay_left_next = delay_left - 1'b1;

      if (pulse) begin
        run_flag_next = 1'b0;
      end else if (expired) begin
        delay_running_next = 1'b0;
        run_flag_next      = 1'b1;
      end

      turn_inc = (turn_count_next == '1) ? turn_count_next : turn_count_next + 1'b1;

      if (phase == PH_COUNT) begin
        if (turns_per_line != '0) begin
          if (restart_pending) begin
            run_flag_next = 1'b1;
          end else if (pulse) begin
            turn_count_next = turn_inc;
            if ({1'b0, turn_inc} >= cut_target) begin
              cut_flag_next = 1'b1;
              phase_next    = PH_WAIT;
            end
          end
        end
      end else if (rlevel) begin
        line_count_next = line_inc;
        if (line_inc == lines_per_roll) roll_count_next = roll_count + 1'b1;
        if (line_inc < lines_per_roll) begin
          delay_left_next    = restart_delay;
          delay_running_next = 1'b1;
        end
        phase_next = PH_COUNT;
      end

      restart_pending_next = 1'b0;
    end
  end

  always_comb begin
    res.run_out        = run_flag_next;
    res.cut_out        = cut_flag_next;
    res.turns_out      = turn_count_next;
    res.lines_out      = line_count_next;
    res.rolls_out      = roll_count_next;
    res.extra_turn_out = (action == ACT_TICK) && plus_one;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COUNT;
      cut_flag        <= 1'b0;
      run_flag        <= 1'b0;
      restart_pending <= 1'b0;
      delay_running   <= 1'b0;
      turn_count      <= '0;
      line_count      <= '0;
      roll_count      <= '0;
      delay_left      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      cut_flag        <= cut_flag_next;
      run_flag        <= run_flag_next;
      restart_pending <= restart_pending_next;
      delay_running   <= delay_running_next;
      turn_count      <= turn_count_next;
      line_count      <= line_count_next;
      roll_count      <= roll_count_next;
      delay_left      <= delay_left_next;
    end
  end

  // cut only comes up together with the move to the wait phase
  a_cut_in_wait: assert property (@(posedge clk) disable iff (rst)
    cut_flag |-> (phase == PH_WAIT))
    else $error("cut asserted outside wait phase");

  a_delay_armed: assert property (@(posedge clk) disable iff (rst)
    (delay_left != '0) |-> delay_running)
    else $error("delay count left without a running delay");

  a_restart_once: assert property (@(posedge clk) disable iff (rst)
    (step && action == ACT_TICK) |=> !restart_pending)
    else $error("restart request survived a tick");

endmodule

@@ design/winding_turn_counter_controller_top.sv @@
// top level of the winding turn counter controller
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      action, count_pin, reset_pin, plus_one_pin
//   out_ch    out  valid/ready      run_out, cut_out, turns_out, lines_out,
//                                   rolls_out, extra_turn_out
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// one item per cycle while out_ch is not stalled: state and filters update at the input
// transfer, and the result is registered in the output register at that transfer
// the result passes through the single output register
// in_ch.ready stays high while the output register is empty or being drained
// a stall on out_ch holds the result and blocks new input only while it lasts
// synchronous reset clears all state but the output data register; configuration returns to its reset values
module winding_turn_counter_controller_top
  import wtc_pkg::*;
#(
  parameter int unsigned COUNT_ON_LEVEL  = 20,
  parameter int unsigned COUNT_OFF_LEVEL = 10,
  parameter int unsigned RESET_ON_LEVEL  = 200,
  parameter int unsigned RESET_OFF_LEVEL = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  wtc_in_if.sink               in_ch,
  wtc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  logic       in_xfer;
  logic       tick;
  logic       reset_clear;
  filt_stat_t cnt_stat;
  filt_stat_t rst_stat;
  result_t    res_next;
  result_t    res;
  logic       out_valid;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign tick        = in_xfer && (in_ch.action == ACT_TICK);

  wtc_filter #(
    .ON_LEVEL  (COUNT_ON_LEVEL),
    .OFF_LEVEL (COUNT_OFF_LEVEL)
  ) u_count_filter (
    .clk   (clk),
    .rst   (rst),
    .step  (tick),
    .pin   (in_ch.count_pin),
    .clear (1'b0),
    .stat  (cnt_stat)
  );

  wtc_filter #(
    .ON_LEVEL  (RESET_ON_LEVEL),
    .OFF_LEVEL (RESET_OFF_LEVEL)
  ) u_reset_filter (
    .clk   (clk),
    .rst   (rst),
    .step  (tick),
    .pin   (in_ch.reset_pin),
    .clear (reset_clear),
    .stat  (rst_stat)
  );

  wtc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (in_xfer),
    .action      (in_ch.action),
    .plus_one    (in_ch.plus_one_pin),
    .cnt_stat    (cnt_stat),
    .rst_stat    (rst_stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .reset_clear (reset_clear),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res <= res_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.run_out        = res.run_out;
  assign out_ch.cut_out        = res.cut_out;
  assign out_ch.turns_out      = res.turns_out;
  assign out_ch.lines_out      = res.lines_out;
  assign out_ch.rolls_out      = res.rolls_out;
  assign out_ch.extra_turn_out = res.extra_turn_out;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("input transfer produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input blocked with empty output register");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule
